// ----- hw/rtl/mhpq_pkg.sv -----
// Shared types and constants for the min-heap priority queue.
// No dependencies; imported by mhpq_core and min_heap_priority_queue.
package mhpq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_CNT_W = 11;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] distance;
    logic [15:0] idx;
  } entry_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] node_index;
    logic [31:0] distance_in;
  } mhpq_req_t;

  typedef struct packed {
    status_e              status;
    logic                 is_empty;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [31:0]          top_distance;
    logic [15:0]          top_index;
  } mhpq_res_t;

endpackage

// ----- hw/rtl/mhpq_core.sv -----
// Heap storage and sift sequencer for the min-heap priority queue.
// Depends on mhpq_pkg.
module mhpq_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mhpq_pkg::mhpq_req_t req_i,
  output logic               idle_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output mhpq_pkg::mhpq_res_t res_o
);
  import mhpq_pkg::*;

  localparam int unsigned LW = ADDR_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_LAST,
    S_DN_CHK,
    S_DN_CMP,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  entry_t            cur_q, cur_d;
  entry_t            root_q, root_d;
  status_e           status_q, status_d;

  // heap storage: one write port, two registered read ports
  entry_t            mem_q [CAPACITY];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  entry_t            rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  logic [ADDR_W-1:0] parent;
  logic [LW-1:0]     lchild, rchild, count_ext;
  logic              has_r, l_below, r_below, take_l;

  assign parent    = (pos_q - ADDR_W'(1)) >> 1;
  assign lchild    = {1'b0, pos_q, 1'b1};
  assign rchild    = {1'b0, pos_q, 1'b0} + LW'(2);
  assign count_ext = LW'(count_q);
  assign has_r     = rchild < count_ext;
  assign l_below   = rd_a_q.distance < cur_q.distance;
  assign r_below   = has_r && (rd_b_q.distance < cur_q.distance);
  assign take_l    = !has_r || (l_below && (rd_a_q.distance < rd_b_q.distance));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = cur_q;
    rd_addr_a = parent;
    rd_addr_b = rchild[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = ST_OK;
          if (req_i.mode == MODE_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              pos_d   = count_q[ADDR_W-1:0];
              cur_d   = '{distance: req_i.distance_in, idx: req_i.node_index};
              count_d = count_q + CNT_W'(1);
              state_d = S_UP_CHK;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              count_d   = count_q - CNT_W'(1);
              rd_addr_a = count_d[ADDR_W-1:0];
              state_d   = S_LAST;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cur_q.distance < rd_a_q.distance) begin
          mem_wdata = rd_a_q;
          pos_d     = parent;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LAST: begin
        cur_d   = rd_a_q;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        rd_addr_a = lchild[ADDR_W-1:0];
        if (lchild >= count_ext) begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (!l_below && !r_below) begin
          state_d = S_DONE;
        end else if (take_l) begin
          mem_wdata = rd_a_q;
          pos_d     = lchild[ADDR_W-1:0];
          state_d   = S_DN_CHK;
        end else begin
          mem_wdata = rd_b_q;
          pos_d     = rchild[ADDR_W-1:0];
          state_d   = S_DN_CHK;
        end
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // cached root keeps the result off the memory read ports
  always_comb begin
    root_d = root_q;
    if (mem_we && (mem_waddr == '0)) root_d = mem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pos_q    <= '0;
      cur_q    <= '0;
      root_q   <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      cur_q    <= cur_d;
      root_q   <= root_d;
      status_q <= status_d;
    end
  end

  logic empty;
  assign empty = (count_q == '0);

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o.status       = status_q;
  assign res_o.is_empty     = empty;
  assign res_o.entry_count  = count_q[OUT_CNT_W-1:0];
  assign res_o.top_distance = empty ? 32'd0 : root_q.distance;
  assign res_o.top_index    = empty ? 16'd0 : root_q.idx;

endmodule

// ----- hw/rtl/min_heap_priority_queue.sv -----
// Top level of the min-heap priority queue: stream ports and result register.
// Depends on mhpq_pkg and mhpq_core.
//
// channel | dir | tdata (low bit up)                               | tuser
// s_axis  | in  | node_index[15:0], distance_in[47:16]             | mode
// m_axis  | out | top_index[15:0], top_distance[47:16],            | status[1:0]
//         |     | entry_count[58:48], is_empty[59], zero[63:60]     |
//
// An insert sifts up through at most log2(1024) = 10 levels; each level
// has a heap memory read step, then a compare and write back step.
// A remove first fetches the last entry, then walks at most nine levels
// down. Refused operations (insert when full, remove when empty) go
// straight to the result state.
// Reset clears the count; heap slots are only used below the count.
// s_axis_tready is high only while the sequencer is idle; the result sits
// in an output register, so a stalled m_axis holds the sequencer in its
// final state until the register frees up.
module min_heap_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // node_index[15:0], distance_in[47:16]
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // top_index, top_distance, entry_count, is_empty
  output logic [1:0]  m_axis_tuser    // status
);
  import mhpq_pkg::*;

  mhpq_req_t req;
  mhpq_res_t core_res;
  mhpq_res_t res_q;
  logic      out_valid_q;
  logic      core_idle, core_res_valid, core_res_ready;

  assign req.mode        = mode_e'(s_axis_tuser);
  assign req.node_index  = s_axis_tdata[15:0];
  assign req.distance_in = s_axis_tdata[47:16];

  assign s_axis_tready  = core_idle;
  // output register is free, or empties this cycle
  assign core_res_ready = !out_valid_q || m_axis_tready;

  mhpq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && core_idle),
    .req_i       (req),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_ready_i (core_res_ready),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (core_res_valid && core_res_ready) begin
        out_valid_q <= 1'b1;
        res_q       <= core_res;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q.is_empty, res_q.entry_count,
                          res_q.top_distance, res_q.top_index};
  assign m_axis_tuser  = res_q.status;

`ifndef SYNTHESIS
  // sequencer busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second item back to back");

  // an empty heap reports a zero minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.is_empty |-> (res_q.top_distance == '0) && (res_q.top_index == '0))
    else $error("empty heap reports a nonzero minimum");

  // a refused remove only happens on an empty heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == ST_EMPTY) |-> res_q.is_empty)
    else $error("remove refused on a non-empty heap");

  // a refused insert only happens when full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == ST_FULL) |->
      (res_q.entry_count == OUT_CNT_W'(CAPACITY)))
    else $error("insert refused below capacity");
`endif

endmodule
